@@ hdl/svgpte_pkg.sv @@
// ----------------------------------------------------------------------------
// svgpte_pkg
// Types and constants shared by the path-token to absolute-element block.
// ----------------------------------------------------------------------------
`default_nettype none

package svgpte_pkg;

   // command letters (ascii)
   localparam logic [7:0] LTR_UP_M = 8'h4D;
   localparam logic [7:0] LTR_LO_M = 8'h6D;
   localparam logic [7:0] LTR_UP_L = 8'h4C;
   localparam logic [7:0] LTR_LO_L = 8'h6C;
   localparam logic [7:0] LTR_UP_H = 8'h48;
   localparam logic [7:0] LTR_LO_H = 8'h68;
   localparam logic [7:0] LTR_UP_V = 8'h56;
   localparam logic [7:0] LTR_LO_V = 8'h76;
   localparam logic [7:0] LTR_UP_C = 8'h43;
   localparam logic [7:0] LTR_LO_C = 8'h63;
   localparam logic [7:0] LTR_UP_Z = 8'h5A;
   localparam logic [7:0] LTR_LO_Z = 8'h7A;
   localparam logic [7:0] LTR_NONE = 8'h20;

   localparam int unsigned STORE_DEPTH = 5;

   typedef enum logic [1:0] {
      KIND_MOVE  = 2'd0,
      KIND_LINE  = 2'd1,
      KIND_CUBIC = 2'd2,
      KIND_CLOSE = 2'd3
   } elem_kind_type;

   typedef struct packed {
      logic               command;
      logic [7:0]         command_letter;
      logic signed [31:0] number_value;
   } req_item_type;

   typedef struct packed {
      elem_kind_type      element_kind;
      logic signed [31:0] end_x;
      logic signed [31:0] end_y;
      logic signed [31:0] first_ctrl_x;
      logic signed [31:0] first_ctrl_y;
      logic signed [31:0] second_ctrl_x;
      logic signed [31:0] second_ctrl_y;
   } rsp_item_type;

   // number of operands a command letter takes, zero for anything unusable
   function automatic logic [2:0] operands_needed(input logic [7:0] letter);
      logic [2:0] need;
      case (letter) inside
         LTR_UP_M, LTR_LO_M, LTR_UP_L, LTR_LO_L: need = 3'd2;
         LTR_UP_H, LTR_LO_H, LTR_UP_V, LTR_LO_V: need = 3'd1;
         LTR_UP_C, LTR_LO_C:                     need = 3'd6;
         default:                                need = 3'd0;
      endcase
      return need;
   endfunction

endpackage

`default_nettype wire

@@ hdl/svg_path_token_to_absolute_elements_core.sv @@
// ----------------------------------------------------------------------------
// svg_path_token_to_absolute_elements_core
// Latency: a result item is valid on rsp_ in the cycle after its token is accepted.
// Throughput: one token per cycle; the only stall source is a full result
// register held by rsp_stall.
// Reset: synchronous; clears the current point, subpath start, operand count
// and sets the active letter to "no command". The operand store is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module svg_path_token_to_absolute_elements_core #(
   parameter int COORD_WIDTH = 32
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_stall,
   input  svgpte_pkg::req_item_type  req_data,
   output logic                      rsp_valid,
   input  wire                       rsp_stall,
   output svgpte_pkg::rsp_item_type  rsp_data
);
   import svgpte_pkg::*;

   localparam int CW = COORD_WIDTH;
   localparam int EW = (CW > 32) ? CW : 32;

   localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
   localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

   typedef logic signed [CW-1:0] coord_type;

   function automatic coord_type sat_add(input coord_type a, input coord_type b);
      logic signed [CW:0] sum;
      sum = (CW+1)'(a) + (CW+1)'(b);
      if (sum > (CW+1)'(CMAX)) return CMAX;
      if (sum < (CW+1)'(CMIN)) return CMIN;
      return sum[CW-1:0];
   endfunction

   function automatic logic signed [31:0] to_port(input coord_type v);
      return 32'(v);
   endfunction

   // state
   logic [7:0]  active_letter_ff, active_letter_in;
   logic [2:0]  operand_count_ff, operand_count_in;
   coord_type   operand_store_ff [STORE_DEPTH];
   coord_type   current_x_ff, current_x_in;
   coord_type   current_y_ff, current_y_in;
   coord_type   start_x_ff, start_x_in;
   coord_type   start_y_ff, start_y_in;
   logic        rsp_valid_ff;
   rsp_item_type rsp_data_ff, rsp_data_in;

   logic        req_fire;
   logic        rsp_load;
   logic        store_we;
   logic [2:0]  need;
   logic        is_close;
   logic signed [EW-1:0] num_ext;
   coord_type   num_val;
   coord_type   op [6];
   coord_type   rel_x0, rel_y1, rel_x2, rel_y3, rel_x4, rel_y5, rel_v0;
   logic        rel;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign req_fire  = req_valid & ~req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign need     = operands_needed(active_letter_ff);
   assign is_close = (req_data.command_letter == LTR_UP_Z) ||
                     (req_data.command_letter == LTR_LO_Z);
   assign rel      = (active_letter_ff >= 8'h61) && (active_letter_ff <= 8'h7A);

   // clamp the incoming number into the coordinate range
   always_comb begin
      num_ext = EW'(req_data.number_value);
      if (num_ext > EW'(CMAX)) begin
         num_val = CMAX;
      end else if (num_ext < EW'(CMIN)) begin
         num_val = CMIN;
      end else begin
         num_val = num_ext[CW-1:0];
      end
   end

   // last operand comes straight from the token, earlier ones from the store
   always_comb begin
      for (int k = 0; k < STORE_DEPTH; k++) begin
         op[k] = (operand_count_ff == 3'(k)) ? num_val : operand_store_ff[k];
      end
      op[5] = num_val;
   end

   assign rel_x0 = sat_add(op[0], current_x_ff);
   assign rel_y1 = sat_add(op[1], current_y_ff);
   assign rel_x2 = sat_add(op[2], current_x_ff);
   assign rel_y3 = sat_add(op[3], current_y_ff);
   assign rel_x4 = sat_add(op[4], current_x_ff);
   assign rel_y5 = sat_add(op[5], current_y_ff);
   assign rel_v0 = sat_add(op[0], current_y_ff);

   always_comb begin
      coord_type ex, ey;
      active_letter_in = active_letter_ff;
      operand_count_in = operand_count_ff;
      current_x_in     = current_x_ff;
      current_y_in     = current_y_ff;
      start_x_in       = start_x_ff;
      start_y_in       = start_y_ff;
      rsp_load         = 1'b0;
      store_we         = 1'b0;
      ex               = '0;
      ey               = '0;
      rsp_data_in      = '0;
      if (req_fire) begin
         if (req_data.command) begin
            active_letter_in = req_data.command_letter;
            operand_count_in = '0;
            if (is_close) begin
               current_x_in             = start_x_ff;
               current_y_in             = start_y_ff;
               rsp_load                 = 1'b1;
               rsp_data_in.element_kind = KIND_CLOSE;
               rsp_data_in.end_x        = to_port(start_x_ff);
               rsp_data_in.end_y        = to_port(start_y_ff);
            end
         end else if (need != 3'd0) begin
            if (({1'b0, operand_count_ff} + 4'd1) < {1'b0, need}) begin
               store_we         = 1'b1;
               operand_count_in = operand_count_ff + 3'd1;
            end else begin
               operand_count_in = '0;
               rsp_load         = 1'b1;
               case (active_letter_ff) inside
                  LTR_UP_M, LTR_LO_M, LTR_UP_L, LTR_LO_L: begin
                     ex           = rel ? rel_x0 : op[0];
                     ey           = rel ? rel_y1 : op[1];
                     current_x_in = ex;
                     current_y_in = ey;
                     rsp_data_in.end_x = to_port(ex);
                     rsp_data_in.end_y = to_port(ey);
                     if (active_letter_ff == LTR_UP_M || active_letter_ff == LTR_LO_M) begin
                        start_x_in               = ex;
                        start_y_in               = ey;
                        active_letter_in         = rel ? LTR_LO_L : LTR_UP_L;
                        rsp_data_in.element_kind = KIND_MOVE;
                     end else begin
                        rsp_data_in.element_kind = KIND_LINE;
                     end
                  end
                  LTR_UP_H, LTR_LO_H: begin
                     ex                       = rel ? rel_x0 : op[0];
                     current_x_in             = ex;
                     rsp_data_in.element_kind = KIND_LINE;
                     rsp_data_in.end_x        = to_port(ex);
                     rsp_data_in.end_y        = to_port(current_y_ff);
                  end
                  LTR_UP_V, LTR_LO_V: begin
                     ey                       = rel ? rel_v0 : op[0];
                     current_y_in             = ey;
                     rsp_data_in.element_kind = KIND_LINE;
                     rsp_data_in.end_x        = to_port(current_x_ff);
                     rsp_data_in.end_y        = to_port(ey);
                  end
                  default: begin
                     ex           = rel ? rel_x4 : op[4];
                     ey           = rel ? rel_y5 : op[5];
                     current_x_in = ex;
                     current_y_in = ey;
                     rsp_data_in.element_kind  = KIND_CUBIC;
                     rsp_data_in.end_x         = to_port(ex);
                     rsp_data_in.end_y         = to_port(ey);
                     rsp_data_in.first_ctrl_x  = to_port(rel ? rel_x0 : op[0]);
                     rsp_data_in.first_ctrl_y  = to_port(rel ? rel_y1 : op[1]);
                     rsp_data_in.second_ctrl_x = to_port(rel ? rel_x2 : op[2]);
                     rsp_data_in.second_ctrl_y = to_port(rel ? rel_y3 : op[3]);
                  end
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_letter_ff <= LTR_NONE;
         operand_count_ff <= '0;
         current_x_ff     <= '0;
         current_y_ff     <= '0;
         start_x_ff       <= '0;
         start_y_ff       <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         active_letter_ff <= active_letter_in;
         operand_count_ff <= operand_count_in;
         current_x_ff     <= current_x_in;
         current_y_ff     <= current_y_in;
         start_x_ff       <= start_x_in;
         start_y_ff       <= start_y_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         operand_store_ff[operand_count_ff] <= num_val;
      end
   end

   // a close letter always produces a close item next cycle
   a_close_emits: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_data.command && is_close) |=>
         (rsp_valid && rsp_data.element_kind == KIND_CLOSE))
      else $error("close letter did not produce a close item");

   // partial operand count always stays below what the active letter needs
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (operand_count_ff != 3'd0) |-> (operand_count_ff < need))
      else $error("operand count out of range for active letter");

   // only cubic items carry control points
   a_ctrl_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.element_kind != KIND_CUBIC) |->
         (rsp_data.first_ctrl_x == '0 && rsp_data.first_ctrl_y == '0 &&
          rsp_data.second_ctrl_x == '0 && rsp_data.second_ctrl_y == '0))
      else $error("control point set on a non-cubic item");

   // no item appears without an accepted token
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      (!req_fire && !(rsp_valid && rsp_stall)) |=> !rsp_valid)
      else $error("result item without an accepted token");

endmodule

`default_nettype wire

@@ test/tb_svg_path_token_to_absolute_elements_core.sv @@
// ----------------------------------------------------------------------------
// tb_svg_path_token_to_absolute_elements_core
// Feeds path-data tokens (command letters and Q16.16 numbers) into the core
// and checks every emitted move, line, cubic and close element. The run starts
// with a short scripted token sequence, then random command sequences. Both
// sides idle at random, and the result side holds off now and then so that
// the core backs up.
// ----------------------------------------------------------------------------
module tb_svg_path_token_to_absolute_elements_core;
   import svgpte_pkg::*;

   localparam logic signed [31:0] COORD_MAX = 32'sh7fff_ffff;
   localparam logic signed [31:0] COORD_MIN = 32'sh8000_0000;
   localparam int unsigned TOKEN_TARGET = 1950;

   typedef enum logic [1:0] {
      BY_MODEL   = 2'd0,
      GIVEN_ELEM = 2'd1,
      GIVEN_NONE = 2'd2
   } check_mode_type;

   typedef struct packed {
      req_item_type   tok;
      check_mode_type how;
      rsp_item_type   elem;
   } script_row_type;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_item_type req_data;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_item_type rsp_data;

   // path state as the core should hold it
   logic [7:0]         pen_letter;
   int unsigned        args_held;
   logic signed [31:0] arg_store [6];
   logic signed [31:0] pen_x, pen_y, start_x, start_y;

   rsp_item_type   pending_elems [$];
   script_row_type opening_script [$];
   logic [7:0]     path_letters [12];
   int unsigned    mismatches = 0;
   int unsigned    tokens_used = 0;
   bit             sender_calm = 1'b0;
   int unsigned    sender_calm_left = 0;
   bit             long_hold_req = 1'b0;

   svg_path_token_to_absolute_elements_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   initial begin
      #10_000_000;
      $display("FAIL svg_path_token_to_absolute_elements_core");
      $finish;
   end

   function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
      logic signed [32:0] s;
      s = {a[31], a} + {b[31], b};
      if (s[32] != s[31]) return s[32] ? COORD_MIN : COORD_MAX;
      return s[31:0];
   endfunction

   function automatic int unsigned operand_total(input logic [7:0] l);
      case (l)
         LTR_UP_M, LTR_LO_M, LTR_UP_L, LTR_LO_L: return 2;
         LTR_UP_H, LTR_LO_H, LTR_UP_V, LTR_LO_V: return 1;
         LTR_UP_C, LTR_LO_C:                     return 6;
         default:                                return 0;
      endcase
   endfunction

   function automatic req_item_type letter_tok(input logic [7:0] l);
      req_item_type t;
      t.command        = 1'b1;
      t.command_letter = l;
      t.number_value   = $urandom;
      return t;
   endfunction

   function automatic req_item_type number_tok(input logic signed [31:0] v);
      req_item_type t;
      t.command        = 1'b0;
      t.command_letter = 8'($urandom_range(0, 255));
      t.number_value   = v;
      return t;
   endfunction

   function automatic rsp_item_type flat_elem(input elem_kind_type k,
                                              input logic signed [31:0] x,
                                              input logic signed [31:0] y);
      rsp_item_type e;
      e = '0;
      e.element_kind = k;
      e.end_x        = x;
      e.end_y        = y;
      return e;
   endfunction

   function automatic logic signed [31:0] pick_coord();
      case ($urandom_range(0, 7))
         0:       return COORD_MAX;
         1:       return COORD_MIN;
         2:       return 32'sd0;
         3:       return -32'sd1;
         4, 5:    return $urandom;
         default: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
      endcase
   endfunction

   task automatic track_path_token(input req_item_type tok, output bit emits,
                                   output bit consumed, output rsp_item_type elem);
      int unsigned        need;
      bit                 rel;
      logic signed [31:0] x, y;
      emits    = 1'b0;
      consumed = 1'b1;
      elem     = '0;
      if (tok.command) begin
         pen_letter = tok.command_letter;
         args_held  = 0;
         if (tok.command_letter == LTR_UP_Z || tok.command_letter == LTR_LO_Z) begin
            pen_x = start_x;
            pen_y = start_y;
            elem  = flat_elem(KIND_CLOSE, pen_x, pen_y);
            emits = 1'b1;
         end
         return;
      end
      need = operand_total(pen_letter);
      if (need == 0) begin
         consumed = 1'b0;
         return;
      end
      arg_store[3'(args_held)] = tok.number_value;
      args_held++;
      if (args_held < need) return;
      args_held = 0;
      rel   = pen_letter[5];
      emits = 1'b1;
      case (pen_letter)
         LTR_UP_M, LTR_LO_M, LTR_UP_L, LTR_LO_L: begin
            x = rel ? add_sat(arg_store[0], pen_x) : arg_store[0];
            y = rel ? add_sat(arg_store[1], pen_y) : arg_store[1];
            pen_x = x;
            pen_y = y;
            if (pen_letter == LTR_UP_M || pen_letter == LTR_LO_M) begin
               start_x    = x;
               start_y    = y;
               // further pairs after a move are lines of the same case
               pen_letter = rel ? LTR_LO_L : LTR_UP_L;
               elem       = flat_elem(KIND_MOVE, x, y);
            end else begin
               elem = flat_elem(KIND_LINE, x, y);
            end
         end
         LTR_UP_H, LTR_LO_H: begin
            pen_x = rel ? add_sat(arg_store[0], pen_x) : arg_store[0];
            elem  = flat_elem(KIND_LINE, pen_x, pen_y);
         end
         LTR_UP_V, LTR_LO_V: begin
            pen_y = rel ? add_sat(arg_store[0], pen_y) : arg_store[0];
            elem  = flat_elem(KIND_LINE, pen_x, pen_y);
         end
         default: begin
            // in relative form all three points are offsets from the point before the curve
            elem.element_kind  = KIND_CUBIC;
            elem.first_ctrl_x  = rel ? add_sat(arg_store[0], pen_x) : arg_store[0];
            elem.first_ctrl_y  = rel ? add_sat(arg_store[1], pen_y) : arg_store[1];
            elem.second_ctrl_x = rel ? add_sat(arg_store[2], pen_x) : arg_store[2];
            elem.second_ctrl_y = rel ? add_sat(arg_store[3], pen_y) : arg_store[3];
            elem.end_x         = rel ? add_sat(arg_store[4], pen_x) : arg_store[4];
            elem.end_y         = rel ? add_sat(arg_store[5], pen_y) : arg_store[5];
            pen_x = elem.end_x;
            pen_y = elem.end_y;
         end
      endcase
   endtask

   task automatic send_token(input req_item_type tok, input check_mode_type how,
                             input rsp_item_type given);
      int unsigned  gap;
      bit           emits, consumed;
      rsp_item_type elem;
      if (sender_calm_left == 0) begin
         sender_calm      = ($urandom_range(0, 3) == 0);
         sender_calm_left = $urandom_range(20, 80);
      end else begin
         sender_calm_left--;
      end
      gap = sender_calm ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= tok;
      do @(posedge clock); while (req_stall);
      track_path_token(tok, emits, consumed, elem);
      if (consumed) tokens_used++;
      case (how)
         BY_MODEL:   if (emits) pending_elems.push_back(elem);
         GIVEN_ELEM: pending_elems.push_back(given);
         default:    ;
      endcase
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %h, got %h", name, want, got);
         mismatches++;
      end
   endtask

   initial begin : result_side
      int unsigned  hold;
      int unsigned  calm_left;
      bit           calm;
      rsp_item_type want;
      hold      = 0;
      calm_left = 0;
      calm      = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (pending_elems.size() == 0) begin
               $error("element_kind: expected nothing, got %0d", rsp_data.element_kind);
               mismatches++;
            end else begin
               want = pending_elems.pop_front();
               check_field("element_kind", 32'(want.element_kind),
                           32'(rsp_data.element_kind));
               check_field("end_x", want.end_x, rsp_data.end_x);
               check_field("end_y", want.end_y, rsp_data.end_y);
               check_field("first_ctrl_x", want.first_ctrl_x, rsp_data.first_ctrl_x);
               check_field("first_ctrl_y", want.first_ctrl_y, rsp_data.first_ctrl_y);
               check_field("second_ctrl_x", want.second_ctrl_x, rsp_data.second_ctrl_x);
               check_field("second_ctrl_y", want.second_ctrl_y, rsp_data.second_ctrl_y);
            end
            if (calm_left == 0) begin
               calm      = ($urandom_range(0, 3) == 0);
               calm_left = $urandom_range(10, 60);
            end else begin
               calm_left--;
            end
            hold = calm ? 0 : $urandom_range(0, 18);
         end
         @(negedge clock);
         if (long_hold_req) begin
            hold          = 150;
            long_hold_req = 1'b0;
         end
         rsp_stall <= (hold > 0);
         if (hold > 0) hold--;
      end
   end

   initial begin : token_side
      int unsigned  need, groups, n, next_squeeze;
      logic [7:0]   ltr;
      req_item_type tok;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_data   = '0;
      pen_letter = LTR_NONE;
      args_held  = 0;
      pen_x      = '0;
      pen_y      = '0;
      start_x    = '0;
      start_y    = '0;
      path_letters = '{LTR_UP_M, LTR_LO_M, LTR_UP_L, LTR_LO_L, LTR_UP_H, LTR_LO_H,
                       LTR_UP_V, LTR_LO_V, LTR_UP_C, LTR_LO_C, LTR_UP_Z, LTR_LO_Z};

      // number with no command, then close straight out of reset
      opening_script.push_back('{number_tok(32'sh0000_1234), GIVEN_NONE, '0});
      opening_script.push_back('{letter_tok(LTR_UP_Z), GIVEN_ELEM,
                                 flat_elem(KIND_CLOSE, 32'sd0, 32'sd0)});
      opening_script.push_back('{letter_tok(LTR_UP_M), GIVEN_NONE, '0});
      opening_script.push_back('{number_tok(COORD_MAX), GIVEN_NONE, '0});
      opening_script.push_back('{number_tok(COORD_MIN), GIVEN_ELEM,
                                 flat_elem(KIND_MOVE, COORD_MAX, COORD_MIN)});
      // half a continuation pair, dropped by the next letter
      opening_script.push_back('{number_tok(32'sd1), GIVEN_NONE, '0});
      opening_script.push_back('{letter_tok(LTR_UP_L), GIVEN_NONE, '0});
      opening_script.push_back('{number_tok(32'sd3), GIVEN_NONE, '0});
      opening_script.push_back('{number_tok(32'sd4), GIVEN_ELEM,
                                 flat_elem(KIND_LINE, 32'sd3, 32'sd4)});
      opening_script.push_back('{letter_tok(LTR_LO_H), BY_MODEL, '0});
      opening_script.push_back('{number_tok(COORD_MIN), BY_MODEL, '0});
      opening_script.push_back('{letter_tok(LTR_UP_V), BY_MODEL, '0});
      opening_script.push_back('{number_tok(-32'sd1), BY_MODEL, '0});
      opening_script.push_back('{letter_tok(LTR_LO_C), BY_MODEL, '0});
      opening_script.push_back('{number_tok(COORD_MAX), BY_MODEL, '0});
      opening_script.push_back('{number_tok(32'sd1), BY_MODEL, '0});
      opening_script.push_back('{number_tok(COORD_MIN), BY_MODEL, '0});
      opening_script.push_back('{number_tok(32'sd0), BY_MODEL, '0});
      opening_script.push_back('{number_tok(32'sd5), BY_MODEL, '0});
      opening_script.push_back('{number_tok(32'sd7), BY_MODEL, '0});
      opening_script.push_back('{letter_tok(LTR_LO_Z), BY_MODEL, '0});
      // unknown letter swallows numbers
      opening_script.push_back('{letter_tok(8'hFF), GIVEN_NONE, '0});
      opening_script.push_back('{number_tok(32'sd9), GIVEN_NONE, '0});
      opening_script.push_back('{letter_tok(LTR_LO_M), BY_MODEL, '0});
      opening_script.push_back('{number_tok(-32'sd1), BY_MODEL, '0});
      opening_script.push_back('{number_tok(COORD_MAX), BY_MODEL, '0});
      opening_script.push_back('{number_tok(32'sd2), BY_MODEL, '0});
      opening_script.push_back('{number_tok(32'sd2), BY_MODEL, '0});

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (opening_script[i])
         send_token(opening_script[i].tok, opening_script[i].how, opening_script[i].elem);

      next_squeeze = 500;
      while (tokens_used < TOKEN_TARGET) begin
         if (tokens_used >= next_squeeze) begin
            // result side holds off while tokens keep coming
            long_hold_req    = 1'b1;
            sender_calm      = 1'b1;
            sender_calm_left = 80;
            next_squeeze    += 800;
         end
         if ($urandom_range(0, 19) == 0) begin
            repeat ($urandom_range(1, 4)) begin
               tok.command        = 1'($urandom_range(0, 1));
               tok.command_letter = 8'($urandom_range(0, 255));
               tok.number_value   = $urandom;
               send_token(tok, BY_MODEL, '0);
            end
         end else begin
            ltr  = path_letters[4'($urandom_range(0, 11))];
            need = operand_total(ltr);
            send_token(letter_tok(ltr), BY_MODEL, '0);
            if (need == 0) begin
               repeat ($urandom_range(0, 2)) send_token(number_tok(pick_coord()), BY_MODEL, '0);
            end else begin
               groups = $urandom_range(1, 3);
               repeat (groups) begin
                  n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, need - 1) : need;
                  repeat (n) send_token(number_tok(pick_coord()), BY_MODEL, '0);
               end
            end
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_elems.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatches == 0)
         $display("PASS svg_path_token_to_absolute_elements_core");
      else
         $display("FAIL svg_path_token_to_absolute_elements_core");
      $finish;
   end

endmodule
